FILE: rtl/assert_macros.svh
// assertion macros shared by the argument splitter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define AS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/asplit_pkg.sv
// types and constants for the argument splitter
package asplit_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 16;
  localparam int OUT_CNT_W      = 16;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OPEN_QUOTE   = 2'd1,
    ST_DANGLING_ESC = 2'd2
  } status_t;

  typedef struct packed {
    logic                 has_res;
    logic [CHAR_W-1:0]    out_char;
    logic                 starts_arg;
    logic                 is_final;
    status_t              status;
    logic [OUT_CNT_W-1:0] arg_count;
    logic [OUT_CNT_W-1:0] char_count;
  } res_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: rtl/argument_splitter_unit.sv
// argument splitter top level: input register, split core, result register
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_ch
// out     | output    | out_valid / out_stall| out_char, out_starts_arg, out_is_final,
//         |           |                      | out_status, out_arg_count, out_char_count
// cfg     | input     | apb, pready always 1 | max_len at byte address 0
//
// one byte per cycle sustained while the result register is not stalled; a taken byte
// passes through the input register, then split logic into the result register
// the split state updates once per byte, which sets the rate
// synchronous active-low reset resets all control state, max_len resets to zero
// out_stall holds the result register; in_stall rises only when the input register
// also holds a byte behind a stalled result
`include "assert_macros.svh"
module argument_splitter_unit #(
  parameter int COUNT_BITS = asplit_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [asplit_pkg::CHAR_W-1:0]       in_ch,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [asplit_pkg::CHAR_W-1:0]       out_char,
  output logic                                out_starts_arg,
  output logic                                out_is_final,
  output logic [1:0]                          out_status,
  output logic [asplit_pkg::OUT_CNT_W-1:0]    out_arg_count,
  output logic [asplit_pkg::OUT_CNT_W-1:0]    out_char_count,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [asplit_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [asplit_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [asplit_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                                cfg_pready
);
  import asplit_pkg::*;

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_ch_r;
  logic              out_valid_r;
  res_t              out_r;
  res_t              res;
  logic [LEN_W-1:0]  max_len;
  logic              proc_ok;
  logic              step;

  asplit_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_len     (max_len)
  );

  asplit_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .ch      (s1_ch_r),
    .max_len (max_len),
    .res     (res)
  );

  assign proc_ok  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && proc_ok;
  assign in_stall = s1_valid_r && !proc_ok;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_ch_r <= in_ch;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.has_res) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_r.out_char;
  assign out_starts_arg = out_r.starts_arg;
  assign out_is_final   = out_r.is_final;
  assign out_status     = out_r.status;
  assign out_arg_count  = out_r.arg_count;
  assign out_char_count = out_r.char_count;

  `AS_NEVER(a_byte_nonzero, out_valid_r && !out_r.is_final && (out_r.out_char == CH_END), "byte result carries terminator")
  `AS_ASSERT(a_stall_holds_input, (in_stall && in_valid) |=> s1_valid_r, "input register lost a byte under stall")

endmodule

FILE: rtl/asplit_cfg.sv
// configuration register file with apb-style access
module asplit_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [asplit_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [asplit_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [asplit_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                                cfg_pready,
  output logic [asplit_pkg::LEN_W-1:0]        max_len
);
  import asplit_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic             wr_en;
  logic             reg_idx;

  assign reg_idx = cfg_paddr[APB_ADDR_W-1];
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '0;
    end else if (wr_en && (reg_idx == REG_MAX_LEN)) begin
      max_len_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_MAX_LEN) begin
      cfg_prdata = {{(APB_DATA_W-LEN_W){1'b0}}, max_len_r};
    end
  end

  assign cfg_pready = 1'b1;
  assign max_len    = max_len_r;

endmodule

FILE: rtl/asplit_core.sv
// split state and per-byte classification logic
`include "assert_macros.svh"
module asplit_core #(
  parameter int COUNT_BITS = asplit_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [asplit_pkg::CHAR_W-1:0]  ch,
  input  logic [asplit_pkg::LEN_W-1:0]   max_len,
  output asplit_pkg::res_t               res
);
  import asplit_pkg::*;

  logic                  esc_r, esc_nxt;
  logic                  quote_r, quote_nxt;
  logic                  newarg_r, newarg_nxt;
  logic                  limit_r, limit_nxt;
  logic [LEN_W-1:0]      idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] args_r, args_nxt;
  logic [COUNT_BITS-1:0] chars_r, chars_nxt;

  logic                  is_end;
  logic                  at_limit;
  logic                  kept;
  logic [OUT_CNT_W-1:0]  args_out;
  logic [OUT_CNT_W-1:0]  chars_out;
  status_t               status;

  assign is_end   = (ch == CH_END);
  assign at_limit = limit_r || ((max_len != '0) && (idx_r >= max_len));
  assign kept     = !is_end && !at_limit &&
                    (esc_r || ((ch != CH_ESC) && (ch != CH_QUOTE) &&
                               (quote_r || !is_space(ch))));

  // counts clipped or zero-extended to the 16-bit summary fields
  generate
    if (COUNT_BITS > OUT_CNT_W) begin : g_clip
      assign args_out  = (|args_r[COUNT_BITS-1:OUT_CNT_W]) ? '1 : args_r[OUT_CNT_W-1:0];
      assign chars_out = (|chars_r[COUNT_BITS-1:OUT_CNT_W]) ? '1 : chars_r[OUT_CNT_W-1:0];
    end else if (COUNT_BITS == OUT_CNT_W) begin : g_same
      assign args_out  = args_r;
      assign chars_out = chars_r;
    end else begin : g_ext
      assign args_out  = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, args_r};
      assign chars_out = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, chars_r};
    end
  endgenerate

  always_comb begin
    priority if (esc_r) begin
      status = ST_DANGLING_ESC;
    end else if (quote_r) begin
      status = ST_OPEN_QUOTE;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res            = '0;
    res.has_res    = is_end || kept;
    res.is_final   = is_end;
    if (is_end) begin
      res.status     = status;
      res.arg_count  = args_out;
      res.char_count = chars_out;
    end else begin
      res.out_char   = ch;
      res.starts_arg = kept && newarg_r;
    end
  end

  always_comb begin
    esc_nxt    = esc_r;
    quote_nxt  = quote_r;
    newarg_nxt = newarg_r;
    limit_nxt  = limit_r;
    idx_nxt    = idx_r;
    args_nxt   = args_r;
    chars_nxt  = chars_r;
    priority if (is_end) begin
      esc_nxt    = 1'b0;
      quote_nxt  = 1'b0;
      newarg_nxt = 1'b1;
      limit_nxt  = 1'b0;
      idx_nxt    = '0;
      args_nxt   = '0;
      chars_nxt  = '0;
    end else if (at_limit) begin
      limit_nxt = 1'b1;
    end else begin
      idx_nxt = (&idx_r) ? idx_r : idx_r + 1'b1;
      priority if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (ch == CH_ESC) begin
        esc_nxt = 1'b1;
      end else if (ch == CH_QUOTE) begin
        quote_nxt  = !quote_r;
        newarg_nxt = 1'b1;
      end else if (!quote_r && is_space(ch)) begin
        newarg_nxt = 1'b1;
      end else begin
      end
      if (kept) begin
        if (newarg_r && !(&args_r)) begin
          args_nxt = args_r + 1'b1;
        end
        if (!(&chars_r)) begin
          chars_nxt = chars_r + 1'b1;
        end
        newarg_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      quote_r  <= 1'b0;
      newarg_r <= 1'b1;
      limit_r  <= 1'b0;
      idx_r    <= '0;
      args_r   <= '0;
      chars_r  <= '0;
    end else if (step) begin
      esc_r    <= esc_nxt;
      quote_r  <= quote_nxt;
      newarg_r <= newarg_nxt;
      limit_r  <= limit_nxt;
      idx_r    <= idx_nxt;
      args_r   <= args_nxt;
      chars_r  <= chars_nxt;
    end
  end

  `AS_ASSERT(a_end_clears, (step && is_end) |=> (!esc_r && !quote_r && newarg_r && !limit_r && args_r == '0), "terminator did not clear split state")
  `AS_NEVER(a_limit_silent, step && limit_r && res.has_res && !res.is_final, "byte result after limit stop")
  `AS_ASSERT(a_start_counts, (step && res.starts_arg) |=> (args_r != '0), "argument start not counted")

endmodule

FILE: tb/sv/testbench.sv
// testbench for the argument splitter: byte driver, result monitor and scoreboard
`timescale 1ns / 1ps

module testbench;
  import asplit_pkg::*;

  localparam int unsigned LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int SPARE_REG = 1;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 140;
  localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = APB_ADDR_W'(4 * int'(REG_MAX_LEN));
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * SPARE_REG);
  localparam logic [CHAR_W-1:0] CH_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X = 8'h78;

  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic                 starts;
    logic                 fin;
    status_t              st;
    logic [OUT_CNT_W-1:0] args;
    logic [OUT_CNT_W-1:0] chars;
  } split_result_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    int unsigned       gap;
  } feed_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAR_W-1:0] in_ch = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic out_starts_arg;
  logic out_is_final;
  logic [1:0] out_status;
  logic [OUT_CNT_W-1:0] out_arg_count;
  logic [OUT_CNT_W-1:0] out_char_count;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // splitter state as the scoreboard sees it
  logic [LEN_W-1:0] len_limit = '0;
  logic esc_pend = 1'b0;
  logic quoting = 1'b0;
  logic arg_due = 1'b1;
  logic [LEN_W-1:0] pos_count = '0;
  logic [CNT_W-1:0] n_args = '0;
  logic [CNT_W-1:0] n_chars = '0;
  logic stopped = 1'b0;

  split_result_t pending_results[$];
  feed_item_t feed_q[$];
  feed_item_t next_feed;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  int unsigned idle_max = 0;
  int unsigned stall_max = 0;
  int unsigned queued_bytes = 0;
  int unsigned cycle_count = 0;
  int fail_count = 0;

  argument_splitter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_starts_arg (out_starts_arg),
    .out_is_final   (out_is_final),
    .out_status     (out_status),
    .out_arg_count  (out_arg_count),
    .out_char_count (out_char_count),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [OUT_CNT_W-1:0] clip_count(input logic [CNT_W-1:0] v);
    if (v > {OUT_CNT_W{1'b1}}) return {OUT_CNT_W{1'b1}};
    return OUT_CNT_W'(v);
  endfunction

  // works out the results of one accepted byte and updates the split state
  task automatic predict_split(input logic [CHAR_W-1:0] c);
    split_result_t r;
    logic keep;
    r = '0;
    keep = 1'b0;
    if (c == CH_END) begin
      r.fin = 1'b1;
      r.st = esc_pend ? ST_DANGLING_ESC : (quoting ? ST_OPEN_QUOTE : ST_OK);
      r.args = clip_count(n_args);
      r.chars = clip_count(n_chars);
      pending_results.push_back(r);
      esc_pend = 1'b0;
      quoting = 1'b0;
      arg_due = 1'b1;
      pos_count = '0;
      n_args = '0;
      n_chars = '0;
      stopped = 1'b0;
    end else if (stopped || (len_limit != 0 && pos_count >= len_limit)) begin
      stopped = 1'b1;
    end else begin
      if (pos_count != '1) pos_count = pos_count + 1'b1;
      if (esc_pend) begin
        esc_pend = 1'b0;
        keep = 1'b1;
      end else if (c == CH_ESC) begin
        esc_pend = 1'b1;
      end else if (c == CH_QUOTE) begin
        quoting = !quoting;
        arg_due = 1'b1;
      end else if (!quoting && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        arg_due = 1'b1;
      end else begin
        keep = 1'b1;
      end
      if (keep) begin
        r.ch = c;
        r.starts = arg_due;
        if (arg_due && n_args != '1) n_args = n_args + 1'b1;
        if (n_chars != '1) n_chars = n_chars + 1'b1;
        arg_due = 1'b0;
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic check_result();
    split_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", {24'h0, out_char}, '0);
    end else begin
      want = pending_results.pop_front();
      if (out_char !== want.ch)
        report_mismatch("out_char", 32'(out_char), 32'(want.ch));
      if (out_starts_arg !== want.starts)
        report_mismatch("out_starts_arg", 32'(out_starts_arg), 32'(want.starts));
      if (out_is_final !== want.fin)
        report_mismatch("out_is_final", 32'(out_is_final), 32'(want.fin));
      if (out_status !== want.st)
        report_mismatch("out_status", 32'(out_status), 32'(want.st));
      if (out_arg_count !== want.args)
        report_mismatch("out_arg_count", 32'(out_arg_count), 32'(want.args));
      if (out_char_count !== want.chars)
        report_mismatch("out_char_count", 32'(out_char_count), 32'(want.chars));
    end
  endtask

  // input side: one byte per transfer, gap drawn per byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) predict_split(in_ch);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (feed_q.size() != 0) begin
          next_feed = feed_q.pop_front();
          in_ch <= next_feed.ch;
          in_valid <= 1'b1;
          gap_left <= next_feed.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: check each transfer, then stall for a drawn count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        stall_draw = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
        stall_left <= stall_draw;
        out_stall <= (stall_draw != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_byte(input logic [CHAR_W-1:0] c);
    feed_item_t it;
    it.ch = c;
    it.gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    feed_q.push_back(it);
    queued_bytes++;
  endtask

  function automatic logic [CHAR_W-1:0] random_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CHAR_W'($urandom_range(8'h61, 8'h7A));
      4: return CH_SPACE;
      5: return CHAR_W'($urandom_range(CH_TAB, CH_CR));
      6: return CH_QUOTE;
      7: return CH_ESC;
      default: return CHAR_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic push_string(input int unsigned len);
    for (int i = 0; i < len; i++) push_byte(random_char());
    if ($urandom_range(0, 7) == 0) push_byte(CH_ESC);
    push_byte(CH_END);
  endtask

  // checked between edges so the driver and monitor updates have settled
  task automatic wait_drained();
    while (feed_q.size() != 0 || in_valid || pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_max_len();
    logic [APB_DATA_W-1:0] rd;
    reg_access(1'b0, MAX_LEN_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(len_limit))
      report_mismatch("max_len readback", rd, 32'(len_limit));
  endtask

  task automatic set_max_len(input logic [LEN_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    wait_drained();
    reg_access(1'b1, MAX_LEN_ADDR, {16'($urandom), v}, rd);
    len_limit = v;
    check_max_len();
  endtask

  initial begin
    logic [APB_DATA_W-1:0] rd;
    logic [LEN_W-1:0] lim;
    int unsigned len;
    int unsigned idle_opts[3];
    idle_opts = '{0, 19, 4};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_max_len();

    // empty string, separators and whitespace, wide bytes
    push_byte(CH_END);
    push_byte(CH_SPACE); push_byte(CH_A); push_byte(CH_TAB); push_byte(8'hFF);
    push_byte(CH_END);
    // quoted space, then a quote left open
    push_byte(CH_QUOTE); push_byte(CH_A); push_byte(CH_SPACE); push_byte(CH_QUOTE);
    push_byte(CH_QUOTE); push_byte(CH_END);
    // escaped quote and escaped space are kept
    push_byte(CH_ESC); push_byte(CH_QUOTE); push_byte(CH_ESC); push_byte(CH_SPACE);
    push_byte(CH_END);
    // open quote with a trailing backslash, then an open quote with one byte
    push_byte(CH_QUOTE); push_byte(CH_ESC); push_byte(CH_END);
    push_byte(CH_QUOTE); push_byte(CH_X); push_byte(CH_END);

    // limit of one byte: leading space uses it up
    set_max_len(16'd1);
    push_byte(CH_SPACE); push_byte(CH_A); push_byte(CH_END);
    push_byte(CH_ESC); push_byte(8'h80); push_byte(CH_END);

    // write to an unused register index leaves max_len alone
    wait_drained();
    reg_access(1'b1, SPARE_ADDR, 32'($urandom), rd);
    check_max_len();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 4: lim = '0;
        1: lim = '1;
        2: lim = 16'd1;
        3: lim = LEN_W'($urandom_range(2, 20));
        5: lim = LEN_W'($urandom_range(0, 65535));
        6: lim = 16'd3;
        default: lim = LEN_W'($urandom_range(4, 30));
      endcase
      set_max_len(lim);
      idle_max = idle_opts[p % 3];
      stall_max = idle_opts[(p + 1) % 3];
      queued_bytes = 0;
      while (queued_bytes < PHASE_BYTES) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
        push_string(len);
      end
    end

    wait_drained();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
